FILE: src/avc_cfg_pkg.sv
// Package for the AVC decoder configuration record parser.
// Holds the parse phase encoding, result codes, constants and the queue entry and result types.
// No dependencies.
`default_nettype none

package avc_cfg_pkg;

    // Parse phases. The numeric value of a phase is also the field kind reported for it.
    typedef enum logic [4:0] {
        PH_VERSION      = 5'd0,
        PH_PROFILE      = 5'd1,
        PH_COMPAT       = 5'd2,
        PH_LEVEL        = 5'd3,
        PH_LENSIZE      = 5'd4,
        PH_SPS_COUNT    = 5'd5,
        PH_SPS_LEN_HI   = 5'd6,
        PH_SPS_LEN_LO   = 5'd7,
        PH_SPS_DATA     = 5'd8,
        PH_PPS_COUNT    = 5'd9,
        PH_PPS_LEN_HI   = 5'd10,
        PH_PPS_LEN_LO   = 5'd11,
        PH_PPS_DATA     = 5'd12,
        PH_CHROMA       = 5'd13,
        PH_LUMA_DEPTH   = 5'd14,
        PH_CHROMA_DEPTH = 5'd15,
        PH_EXT_COUNT    = 5'd16,
        PH_EXT_LEN_HI   = 5'd17,
        PH_EXT_LEN_LO   = 5'd18,
        PH_EXT_DATA     = 5'd19,
        PH_TRAIL        = 5'd20
    } phase_t;

    // Kind reported for bytes that arrive after an error was latched.
    localparam logic [4:0] KIND_IGNORED = 5'd21;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_VERSION   = 2'd1;
    localparam logic [1:0] ERR_EARLY_END = 2'd2;

    localparam logic [7:0] VERSION_ONE    = 8'd1;
    localparam logic [7:0] PROFILE_HIGH   = 8'd100;
    localparam logic [7:0] PROFILE_HIGH10 = 8'd110;
    localparam logic [7:0] PROFILE_HIGH22 = 8'd122;
    localparam logic [7:0] PROFILE_HIGH44 = 8'd144;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One request after the front end has looked at the byte on its own.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
        logic       version_ok;
        logic       profile_high;
        logic [2:0] len_size;
        logic       complete;
    } queue_entry_t;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [7:0]  byte_echo;
        logic [15:0] decoded_value;
        logic        complete_flag;
        logic [7:0]  set_index;
        logic [15:0] payload_offset;
        logic        last_of_set;
        logic        record_done;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: src/avc_config_record_parser_top.sv
// Top level of the AVC decoder configuration record parser.
// Instantiates avc_cfg_front, avc_cfg_queue and avc_cfg_back; uses avc_cfg_pkg.
//
//   Channel   Direction   Handshake           Payload
//   input     in          in_valid/in_stall   in_byte, record_start, record_end
//   output    out         out_valid/out_stall field_kind .. error_code (nine fields)
//
// Every accepted byte yields exactly one result. The parser sustains one byte per
// cycle while the output is not stalled; a byte passes through the queue and then the
// back end result register. The state update in the back end is what bounds the
// rate. Reset (rst_n low) clears the queue, the parse state and the output valid;
// the first byte after reset is parsed as a version byte. A stalled output holds its
// result while the four-entry queue keeps taking bytes; in_stall rises only when that
// queue is full.
`default_nettype none

module avc_config_record_parser_top
    import avc_cfg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        record_start,
    input  wire logic        record_end,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       field_kind,
    output logic [7:0]       byte_echo,
    output logic [15:0]      decoded_value,
    output logic             complete_flag,
    output logic [7:0]       set_index,
    output logic [15:0]      payload_offset,
    output logic             last_of_set,
    output logic             record_done,
    output logic [1:0]       error_code
);

    // Front end to queue: a pre-classified request per accepted byte.
    queue_status_t queue_status;
    queue_entry_t  push_entry;
    queue_entry_t  head_entry;
    logic          push;
    logic          pop;
    result_t       result;

    avc_cfg_front u_front
    (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .record_start (record_start),
        .record_end   (record_end),
        .queue_status (queue_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    // The queue lets the front end keep accepting while the output is stalled.
    avc_cfg_queue u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_entry   (push_entry),
        .pop          (pop),
        .head_entry   (head_entry),
        .queue_status (queue_status)
    );

    // The back end owns all record parse state and the output register.
    avc_cfg_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result)
    );

    assign field_kind     = result.field_kind;
    assign byte_echo      = result.byte_echo;
    assign decoded_value  = result.decoded_value;
    assign complete_flag  = result.complete_flag;
    assign set_index      = result.set_index;
    assign payload_offset = result.payload_offset;
    assign last_of_set    = result.last_of_set;
    assign record_done    = result.record_done;
    assign error_code     = result.error_code;

endmodule

`default_nettype wire

FILE: src/avc_cfg_front.sv
// Front end of the configuration record parser: accepts input requests and pre-classifies
// each byte on its own (version check, profile class, length size). Uses avc_cfg_pkg.
`default_nettype none

module avc_cfg_front
    import avc_cfg_pkg::*;
(
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    in_byte,
    input  wire logic          record_start,
    input  wire logic          record_end,
    input  wire queue_status_t queue_status,
    output logic               push,
    output queue_entry_t       push_entry
);

    assign in_stall = queue_status.full;
    assign push     = in_valid && !queue_status.full;

    always_comb
    begin
        push_entry.data         = in_byte;
        push_entry.start        = record_start;
        push_entry.last         = record_end;
        push_entry.version_ok   = (in_byte == VERSION_ONE);
        push_entry.profile_high = (in_byte == PROFILE_HIGH)   || (in_byte == PROFILE_HIGH10) ||
                                  (in_byte == PROFILE_HIGH22) || (in_byte == PROFILE_HIGH44);
        push_entry.len_size     = {1'b0, in_byte[1:0]} + 3'd1;
        push_entry.complete     = in_byte[7];
    end

endmodule

`default_nettype wire

FILE: src/avc_cfg_queue.sv
// Short request queue between the parser front end and back end.
// Register-based circular buffer of queue_entry_t. Uses avc_cfg_pkg.
`default_nettype none

module avc_cfg_queue
    import avc_cfg_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire queue_entry_t  push_entry,
    input  wire logic          pop,
    output queue_entry_t       head_entry,
    output queue_status_t      queue_status
);

    queue_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg;
    logic [QUEUE_AW:0]       count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry         = mem_reg[rd_ptr_reg];
    assign queue_status.full  = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign queue_status.empty = (count_reg == '0);

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue holds more entries than its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> pop)
        else $error("queue written while full");
`endif

endmodule

`default_nettype wire

FILE: src/avc_cfg_back.sv
// Back end of the configuration record parser: walks the record state machine one queued
// byte per cycle while not stalled, holding the result in an output register. Uses avc_cfg_pkg.
`default_nettype none

module avc_cfg_back
    import avc_cfg_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_status_t queue_status,
    input  wire queue_entry_t  head_entry,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output result_t            result
);

    phase_t       phase_reg,      phase_next;
    logic         high_reg,       high_next;
    logic [7:0]   sets_left_reg,  sets_left_next;
    logic [7:0]   set_cnt_reg,    set_cnt_next;
    logic [15:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]   len_hi_reg,     len_hi_next;
    logic [15:0]  offset_reg,     offset_next;
    logic         err_reg,        err_next;
    logic         out_valid_reg;
    result_t      res_reg,        res_next;

    // State as seen by the current byte: a record start clears it first.
    phase_t       cur_phase;
    logic         cur_high;
    logic [7:0]   cur_left;
    logic [7:0]   cur_cnt;
    logic [15:0]  cur_bytes;
    logic [7:0]   cur_len_hi;
    logic [15:0]  cur_offset;
    logic         cur_err;

    phase_t       list_base;
    phase_t       after_list_phase;
    logic         after_list_done;
    logic [7:0]   count_value;
    logic [15:0]  len_full;
    logic [15:0]  bytes_dec;
    logic [7:0]   sets_dec;
    logic         is_count;
    logic         is_len_lo;
    logic         is_data;
    logic         set_ends;
    logic         list_ends;
    logic         done;
    logic         err_version;
    logic [4:0]   kind;
    logic         err_early;

    assign pop = !queue_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cur_phase  = head_entry.start ? PH_VERSION : phase_reg;
        cur_high   = head_entry.start ? 1'b0  : high_reg;
        cur_left   = head_entry.start ? '0    : sets_left_reg;
        cur_cnt    = head_entry.start ? '0    : set_cnt_reg;
        cur_bytes  = head_entry.start ? '0    : bytes_left_reg;
        cur_len_hi = head_entry.start ? '0    : len_hi_reg;
        cur_offset = head_entry.start ? '0    : offset_reg;
        cur_err    = head_entry.start ? 1'b0  : err_reg;
    end

    // Shared decode of list and set boundaries.
    always_comb
    begin
        if (cur_phase >= PH_EXT_COUNT)
        begin
            list_base = PH_EXT_COUNT;
        end
        else if (cur_phase >= PH_PPS_COUNT)
        begin
            list_base = PH_PPS_COUNT;
        end
        else
        begin
            list_base = PH_SPS_COUNT;
        end

        if (list_base == PH_SPS_COUNT)
        begin
            after_list_phase = PH_PPS_COUNT;
            after_list_done  = 1'b0;
        end
        else if (list_base == PH_PPS_COUNT && cur_high)
        begin
            after_list_phase = PH_CHROMA;
            after_list_done  = 1'b0;
        end
        else
        begin
            after_list_phase = PH_TRAIL;
            after_list_done  = 1'b1;
        end

        count_value = (cur_phase == PH_SPS_COUNT) ? {3'b000, head_entry.data[4:0]}
                                                  : head_entry.data;
        len_full  = {cur_len_hi, head_entry.data};
        bytes_dec = cur_bytes - 16'd1;
        sets_dec  = cur_left - 8'd1;

        is_count  = (cur_phase == PH_SPS_COUNT) || (cur_phase == PH_PPS_COUNT) ||
                    (cur_phase == PH_EXT_COUNT);
        is_len_lo = (cur_phase == PH_SPS_LEN_LO) || (cur_phase == PH_PPS_LEN_LO) ||
                    (cur_phase == PH_EXT_LEN_LO);
        is_data   = (cur_phase == PH_SPS_DATA) || (cur_phase == PH_PPS_DATA) ||
                    (cur_phase == PH_EXT_DATA);

        set_ends  = (is_len_lo && (len_full == '0)) || (is_data && (bytes_dec == '0));
        list_ends = (is_count && (count_value == '0)) || (set_ends && (sets_dec == '0));
        done      = !cur_err && list_ends && after_list_done;

        err_version = !cur_err && (cur_phase == PH_VERSION) && !head_entry.version_ok;

        if (cur_err)
        begin
            kind = KIND_IGNORED;
        end
        else if (cur_phase > PH_EXT_DATA)
        begin
            kind = 5'(PH_TRAIL);
        end
        else
        begin
            kind = 5'(cur_phase);
        end

        err_early = !cur_err && head_entry.last && !done && (kind != 5'(PH_TRAIL)) &&
                    !err_version;
    end

    // Next state of the parse.
    always_comb
    begin
        phase_next      = cur_phase;
        high_next       = cur_high;
        sets_left_next  = cur_left;
        set_cnt_next    = cur_cnt;
        bytes_left_next = cur_bytes;
        len_hi_next     = cur_len_hi;
        offset_next     = cur_offset;
        err_next        = cur_err || err_version || err_early;

        if (!cur_err)
        begin
            unique case (cur_phase) inside
                PH_VERSION:
                begin
                    if (head_entry.version_ok)
                    begin
                        phase_next = PH_PROFILE;
                    end
                end
                PH_PROFILE:
                begin
                    high_next  = head_entry.profile_high;
                    phase_next = PH_COMPAT;
                end
                PH_COMPAT:       phase_next = PH_LEVEL;
                PH_LEVEL:        phase_next = PH_LENSIZE;
                PH_LENSIZE:      phase_next = PH_SPS_COUNT;
                PH_CHROMA:       phase_next = PH_LUMA_DEPTH;
                PH_LUMA_DEPTH:   phase_next = PH_CHROMA_DEPTH;
                PH_CHROMA_DEPTH: phase_next = PH_EXT_COUNT;
                PH_SPS_COUNT, PH_PPS_COUNT, PH_EXT_COUNT:
                begin
                    sets_left_next = count_value;
                    set_cnt_next   = '0;
                    offset_next    = '0;
                    if (count_value == '0)
                    begin
                        phase_next = after_list_phase;
                    end
                    else
                    begin
                        phase_next = phase_t'(cur_phase + 5'd1);
                    end
                end
                PH_SPS_LEN_HI, PH_PPS_LEN_HI, PH_EXT_LEN_HI:
                begin
                    len_hi_next = head_entry.data;
                    phase_next  = phase_t'(cur_phase + 5'd1);
                end
                PH_SPS_LEN_LO, PH_PPS_LEN_LO, PH_EXT_LEN_LO, PH_SPS_DATA, PH_PPS_DATA,
                PH_EXT_DATA:
                begin
                    if (is_len_lo)
                    begin
                        bytes_left_next = len_full;
                        offset_next     = '0;
                    end
                    else
                    begin
                        bytes_left_next = bytes_dec;
                        offset_next     = cur_offset + 16'd1;
                    end
                    if (set_ends)
                    begin
                        set_cnt_next   = cur_cnt + 8'd1;
                        sets_left_next = sets_dec;
                        offset_next    = '0;
                        if (sets_dec == '0)
                        begin
                            phase_next = after_list_phase;
                        end
                        else
                        begin
                            phase_next = phase_t'(5'(list_base) + 5'd1);
                        end
                    end
                    else if (is_len_lo)
                    begin
                        phase_next = phase_t'(cur_phase + 5'd1);
                    end
                end
                default:         phase_next = PH_TRAIL;
            endcase
        end
    end

    // Result of the current byte.
    always_comb
    begin
        res_next                = '0;
        res_next.field_kind     = kind;
        res_next.byte_echo      = head_entry.data;
        res_next.record_done    = done;
        if (err_version)
        begin
            res_next.error_code = ERR_VERSION;
        end
        else if (err_early)
        begin
            res_next.error_code = ERR_EARLY_END;
        end
        else
        begin
            res_next.error_code = ERR_NONE;
        end

        if (!cur_err)
        begin
            unique case (cur_phase) inside
                PH_VERSION, PH_PROFILE, PH_COMPAT, PH_LEVEL, PH_SPS_LEN_HI, PH_PPS_LEN_HI,
                PH_EXT_LEN_HI:
                begin
                    res_next.decoded_value = {8'h00, head_entry.data};
                    if (cur_phase == PH_SPS_LEN_HI || cur_phase == PH_PPS_LEN_HI ||
                        cur_phase == PH_EXT_LEN_HI)
                    begin
                        res_next.set_index = cur_cnt;
                    end
                end
                PH_LENSIZE:
                begin
                    res_next.decoded_value = {13'h0000, head_entry.len_size};
                    res_next.complete_flag = head_entry.complete;
                end
                PH_SPS_COUNT, PH_PPS_COUNT, PH_EXT_COUNT:
                begin
                    res_next.decoded_value = {8'h00, count_value};
                end
                PH_SPS_LEN_LO, PH_PPS_LEN_LO, PH_EXT_LEN_LO:
                begin
                    res_next.decoded_value = len_full;
                    res_next.set_index     = cur_cnt;
                    res_next.last_of_set   = set_ends;
                end
                PH_SPS_DATA, PH_PPS_DATA, PH_EXT_DATA:
                begin
                    res_next.set_index      = cur_cnt;
                    res_next.payload_offset = cur_offset;
                    res_next.last_of_set    = set_ends;
                end
                PH_CHROMA:
                begin
                    res_next.decoded_value = {14'h0000, head_entry.data[1:0]};
                end
                PH_LUMA_DEPTH, PH_CHROMA_DEPTH:
                begin
                    res_next.decoded_value = {13'h0000, head_entry.data[2:0]};
                end
                default:
                begin
                    res_next.decoded_value = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_VERSION;
            high_reg       <= 1'b0;
            sets_left_reg  <= '0;
            set_cnt_reg    <= '0;
            bytes_left_reg <= '0;
            len_hi_reg     <= '0;
            offset_reg     <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                high_reg       <= high_next;
                sets_left_reg  <= sets_left_next;
                set_cnt_reg    <= set_cnt_next;
                bytes_left_reg <= bytes_left_next;
                len_hi_reg     <= len_hi_next;
                offset_reg     <= offset_next;
                err_reg        <= err_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.record_done |-> (res_reg.error_code == ERR_NONE))
        else $error("record reported complete together with an error");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.field_kind == KIND_IGNORED) |->
            (res_reg.error_code == ERR_NONE) && (res_reg.decoded_value == '0))
        else $error("ignored byte carries an error or a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.last_of_set |->
            (res_reg.field_kind == 5'(PH_SPS_LEN_LO)) || (res_reg.field_kind == 5'(PH_SPS_DATA)) ||
            (res_reg.field_kind == 5'(PH_PPS_LEN_LO)) || (res_reg.field_kind == 5'(PH_PPS_DATA)) ||
            (res_reg.field_kind == 5'(PH_EXT_LEN_LO)) || (res_reg.field_kind == 5'(PH_EXT_DATA)))
        else $error("end of set flagged outside a length or payload byte");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for avc_config_record_parser_top: byte-level checks of the record role labeling.
// Depends on avc_cfg_pkg (phase, kind and error codes, result_t) and the parser RTL.

module tb;
    import avc_cfg_pkg::*;

    // No acceptance on either channel for this many cycles means the block hung.
    // Sender gaps and receiver stalls are bounded random bursts and the
    // pipeline is two deep, so a correct run never comes near this.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_TARGET  = 400;
    localparam int TOTAL_TARGET   = 550;
    localparam int MAX_REPORTS    = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        record_start;
    logic        record_end;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  field_kind;
    logic [7:0]  byte_echo;
    logic [15:0] decoded_value;
    logic        complete_flag;
    logic [7:0]  set_index;
    logic [15:0] payload_offset;
    logic        last_of_set;
    logic        record_done;
    logic [1:0]  error_code;

    avc_config_record_parser_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .record_start   (record_start),
        .record_end     (record_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .field_kind     (field_kind),
        .byte_echo      (byte_echo),
        .decoded_value  (decoded_value),
        .complete_flag  (complete_flag),
        .set_index      (set_index),
        .payload_offset (payload_offset),
        .last_of_set    (last_of_set),
        .record_done    (record_done),
        .error_code     (error_code)
    );

    // Parse state of the predictor. It mirrors what the parser must track:
    // where in the record we are, the profile (it decides whether the
    // high-profile tail follows), the set bookkeeping and the error latch.
    phase_t      cur_phase;
    logic [7:0]  prof_seen;
    logic [7:0]  sets_remaining;
    logic [7:0]  set_num;
    logic [15:0] bytes_remaining;
    logic [7:0]  len_hi;
    logic [15:0] offset_num;
    logic        err_latched;

    // Predicted role labels, oldest first, waiting for the parser's results.
    result_t     expected_labels[$];
    result_t     observed_label;
    result_t     wanted_label;

    // Bytes of the record being sent next.
    logic [7:0]  rec_bytes[$];

    int          mismatch_count;
    int          result_count;
    int          parsed_count;
    logic        idle_on;
    logic        stall_on;

    // A profile 100 record: one empty SPS, one PPS of one byte, the
    // high-profile tail with masked bits set, and one empty extension set.
    logic [7:0]  hp_record [0:17] = '{
        8'h01, 8'd100, 8'hFF, 8'h00, 8'h83, 8'hE1, 8'h00, 8'h00, 8'h01,
        8'h00, 8'h01, 8'hAB, 8'hFF, 8'hF8, 8'h0F, 8'h01, 8'h00, 8'h00
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_parse();
        cur_phase       = PH_VERSION;
        prof_seen       = 8'd0;
        sets_remaining  = 8'd0;
        set_num         = 8'd0;
        bytes_remaining = 16'd0;
        len_hi          = 8'd0;
        offset_num      = 16'd0;
        err_latched     = 1'b0;
    endfunction

    // A list of sets is exhausted. SPS is always followed by PPS; PPS is
    // followed by the chroma/depth tail only for the high profiles.
    // Returns 1 when the record is complete.
    function automatic logic finish_list(phase_t base);
        if (base == PH_SPS_COUNT)
        begin
            cur_phase = PH_PPS_COUNT;
            return 1'b0;
        end
        if (base == PH_PPS_COUNT &&
            (prof_seen == PROFILE_HIGH || prof_seen == PROFILE_HIGH10 ||
             prof_seen == PROFILE_HIGH22 || prof_seen == PROFILE_HIGH44))
        begin
            cur_phase = PH_CHROMA;
            return 1'b0;
        end
        cur_phase = PH_TRAIL;
        return 1'b1;
    endfunction

    // One set of a list is over: move to the next set's length, or past the list.
    function automatic logic close_set(phase_t base);
        set_num        = set_num + 8'd1;
        sets_remaining = sets_remaining - 8'd1;
        offset_num     = 16'd0;
        if (sets_remaining == 8'd0)
            return finish_list(base);
        cur_phase = phase_t'(base + 5'd1);
        return 1'b0;
    endfunction

    function automatic phase_t list_of(phase_t p);
        if (p >= PH_EXT_COUNT)
            return PH_EXT_COUNT;
        if (p >= PH_PPS_COUNT)
            return PH_PPS_COUNT;
        return PH_SPS_COUNT;
    endfunction

    // Labels one byte and advances the predicted parse state.
    function automatic result_t label_byte(logic [7:0] b, logic start, logic endm);
        result_t     r;
        phase_t      p;
        logic        done;
        logic [15:0] len;
        logic [7:0]  n;

        r           = '0;
        r.byte_echo = b;
        done        = 1'b0;
        if (start)
            reset_parse();

        if (err_latched)
        begin
            // After an error everything is ignored until the next record start.
            r.field_kind = KIND_IGNORED;
        end
        else
        begin
            p            = cur_phase;
            r.field_kind = p;
            case (p)
                PH_VERSION:
                begin
                    r.decoded_value = {8'd0, b};
                    if (b != VERSION_ONE)
                    begin
                        r.error_code = ERR_VERSION;
                        err_latched  = 1'b1;
                    end
                    else
                        cur_phase = PH_PROFILE;
                end
                PH_PROFILE:
                begin
                    r.decoded_value = {8'd0, b};
                    prof_seen       = b;
                    cur_phase       = PH_COMPAT;
                end
                PH_COMPAT, PH_LEVEL:
                begin
                    r.decoded_value = {8'd0, b};
                    cur_phase       = phase_t'(p + 5'd1);
                end
                PH_LENSIZE:
                begin
                    r.decoded_value = {14'd0, b[1:0]} + 16'd1;
                    r.complete_flag = b[7];
                    cur_phase       = PH_SPS_COUNT;
                end
                PH_SPS_COUNT, PH_PPS_COUNT, PH_EXT_COUNT:
                begin
                    // Only the SPS count is masked to five bits.
                    n               = (p == PH_SPS_COUNT) ? {3'd0, b[4:0]} : b;
                    r.decoded_value = {8'd0, n};
                    sets_remaining  = n;
                    set_num         = 8'd0;
                    offset_num      = 16'd0;
                    if (n == 8'd0)
                        done = finish_list(p);
                    else
                        cur_phase = phase_t'(p + 5'd1);
                end
                PH_SPS_LEN_HI, PH_PPS_LEN_HI, PH_EXT_LEN_HI:
                begin
                    r.decoded_value = {8'd0, b};
                    r.set_index     = set_num;
                    len_hi          = b;
                    cur_phase       = phase_t'(p + 5'd1);
                end
                PH_SPS_LEN_LO, PH_PPS_LEN_LO, PH_EXT_LEN_LO:
                begin
                    len             = {len_hi, b};
                    r.decoded_value = len;
                    r.set_index     = set_num;
                    bytes_remaining = len;
                    offset_num      = 16'd0;
                    // A zero-length set ends right on its low length byte.
                    if (len == 16'd0)
                    begin
                        r.last_of_set = 1'b1;
                        done          = close_set(list_of(p));
                    end
                    else
                        cur_phase = phase_t'(p + 5'd1);
                end
                PH_SPS_DATA, PH_PPS_DATA, PH_EXT_DATA:
                begin
                    r.set_index      = set_num;
                    r.payload_offset = offset_num;
                    offset_num       = offset_num + 16'd1;
                    bytes_remaining  = bytes_remaining - 16'd1;
                    if (bytes_remaining == 16'd0)
                    begin
                        r.last_of_set = 1'b1;
                        done          = close_set(list_of(p));
                    end
                end
                PH_CHROMA:
                begin
                    r.decoded_value = {14'd0, b[1:0]};
                    cur_phase       = PH_LUMA_DEPTH;
                end
                PH_LUMA_DEPTH:
                begin
                    r.decoded_value = {13'd0, b[2:0]};
                    cur_phase       = PH_CHROMA_DEPTH;
                end
                PH_CHROMA_DEPTH:
                begin
                    r.decoded_value = {13'd0, b[2:0]};
                    cur_phase       = PH_EXT_COUNT;
                end
                default:
                begin
                    r.field_kind = PH_TRAIL;
                    cur_phase    = PH_TRAIL;
                end
            endcase
            // An end marker on a byte that does not finish the record is an
            // early end, unless the byte is trailing or already a bad version.
            if (endm && !done && r.field_kind != PH_TRAIL && r.error_code == ERR_NONE)
            begin
                r.error_code = ERR_EARLY_END;
                err_latched  = 1'b1;
            end
        end
        r.record_done = done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Sends one request, with a random gap ahead of it while idling is on.
    // Valid stays high afterward so that back-to-back requests need no
    // second assignment in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic start, input logic endm);
        result_t r;

        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        in_byte      <= b;
        record_start <= start;
        record_end   <= endm;
        do
            @(posedge clk);
        while (in_stall);
        r = label_byte(b, start, endm);
        expected_labels.push_back(r);
        if (r.field_kind != KIND_IGNORED)
            parsed_count++;
    endtask

    // Sends rec_bytes[first .. stop-1], then trail_n random trailing bytes.
    // The end marker, if asked for, goes on the very last byte sent.
    task automatic send_record(input int first, input int stop, input logic with_start,
                               input logic mark_end, input int trail_n);
        for (int i = first; i < stop; i++)
            send_byte(rec_bytes[i], with_start && i == first,
                      mark_end && trail_n == 0 && i == stop - 1);
        for (int j = 0; j < trail_n; j++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, mark_end && j == trail_n - 1);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_labels.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_set(input int max_len);
        int          len;
        logic [15:0] len16;

        len   = $urandom_range(0, max_len);
        len16 = len[15:0];
        rec_bytes.push_back(len16[15:8]);
        rec_bytes.push_back(len16[7:0]);
        repeat (len) rec_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Builds a well-formed record with random content into rec_bytes.
    task automatic build_record(input logic [7:0] profile, input int sps_n, input int pps_n,
                                input int ext_n, input int max_len);
        logic [7:0] count_byte;

        rec_bytes.delete();
        rec_bytes.push_back(VERSION_ONE);
        rec_bytes.push_back(profile);
        rec_bytes.push_back(8'($urandom_range(0, 255)));
        rec_bytes.push_back(8'($urandom_range(0, 255)));
        rec_bytes.push_back(8'($urandom_range(0, 255)));
        // The reserved upper bits of the SPS count byte are random.
        count_byte      = 8'($urandom_range(0, 255));
        count_byte[4:0] = sps_n[4:0];
        rec_bytes.push_back(count_byte);
        repeat (sps_n) add_set(max_len);
        rec_bytes.push_back(pps_n[7:0]);
        repeat (pps_n) add_set(max_len);
        if (profile == PROFILE_HIGH || profile == PROFILE_HIGH10 ||
            profile == PROFILE_HIGH22 || profile == PROFILE_HIGH44)
        begin
            repeat (3) rec_bytes.push_back(8'($urandom_range(0, 255)));
            rec_bytes.push_back(ext_n[7:0]);
            repeat (ext_n) add_set(max_len);
        end
    endtask

    task automatic build_random_record();
        logic [7:0] profile;
        int         max_len;
        int         sps_n;
        int         pps_n;

        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 3))
                0: profile = PROFILE_HIGH;
                1: profile = PROFILE_HIGH10;
                2: profile = PROFILE_HIGH22;
                default: profile = PROFILE_HIGH44;
            endcase
        end
        else
            profile = 8'($urandom_range(0, 255));
        // Mostly short sets; now and then a long list, with the PPS count
        // above 31 so that it shows it is not masked like the SPS count.
        max_len = 6;
        sps_n   = $urandom_range(0, 3);
        pps_n   = $urandom_range(0, 3);
        if ($urandom_range(0, 30) == 0)
        begin
            sps_n   = 31;
            pps_n   = 33;
            max_len = 1;
        end
        build_record(profile, sps_n, pps_n, $urandom_range(0, 2), max_len);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-written records: the first byte after reset without a start
    // marker, every field role but extension data, masked bits, a zero-length
    // set, a trailing byte carrying the end marker, a bad version that also
    // carries the end marker, a byte ignored after that error, a record ended
    // early, and a set with a nonzero high length byte cut off inside its payload.
    task automatic test_directed_records();
        rec_bytes.delete();
        foreach (hp_record[i])
            rec_bytes.push_back(hp_record[i]);
        send_record(0, rec_bytes.size(), 1'b0, 1'b1, 1);

        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(VERSION_ONE, 1'b0, 1'b0);

        send_byte(VERSION_ONE, 1'b1, 1'b0);
        send_byte(8'd66, 1'b0, 1'b1);

        rec_bytes.delete();
        rec_bytes.push_back(VERSION_ONE);
        rec_bytes.push_back(8'd77);
        rec_bytes.push_back(8'h40);
        rec_bytes.push_back(8'd30);
        rec_bytes.push_back(8'hFF);
        rec_bytes.push_back(8'hE1);
        rec_bytes.push_back(8'h01);
        rec_bytes.push_back(8'h2C);
        rec_bytes.push_back(8'h11);
        rec_bytes.push_back(8'h22);
        rec_bytes.push_back(8'h33);
        send_record(0, rec_bytes.size(), 1'b1, 1'b1, 0);
    endtask

    // The sender stops in the middle of a record until every result is
    // back, then finishes the record.
    task automatic test_drain_pause();
        int half;

        build_record(PROFILE_HIGH44, 1, 2, 1, 4);
        half = rec_bytes.size() / 2;
        send_record(0, half, 1'b1, 1'b0, 0);
        pause_until_drained();
        send_record(half, rec_bytes.size(), 1'b0, 1'b1, 0);
    endtask

    // Mostly complete records with random content; the rest are truncated,
    // restarted, bad-version and noise sequences.
    task automatic test_random_records();
        int sel;
        int stop;

        while (parsed_count < RANDOM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            build_random_record();
            if (sel < 55)
            begin
                // Complete record; the end marker is sometimes left off and
                // trailing bytes sometimes follow.
                send_record(0, rec_bytes.size(), 1'b1, $urandom_range(0, 4) != 0,
                            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
            end
            else if (sel < 70)
            begin
                // Ended early, then a few bytes that must be ignored.
                stop = $urandom_range(1, rec_bytes.size() - 1);
                send_record(0, stop, 1'b1, 1'b1, 0);
                repeat ($urandom_range(0, 2))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end
            else if (sel < 80)
            begin
                // Cut off without an end marker; the next record restarts the parse.
                stop = $urandom_range(1, rec_bytes.size() - 1);
                send_record(0, stop, 1'b1, 1'b0, 0);
            end
            else if (sel < 90)
            begin
                // Any version other than one.
                rec_bytes[0] = ($urandom_range(0, 3) == 0) ? 8'h00
                                                           : 8'($urandom_range(2, 255));
                send_record(0, $urandom_range(1, 4), 1'b1, 1'($urandom_range(0, 1)), 0);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 29) == 0)
                pause_until_drained();
        end
    endtask

    // Closing stretch with no idling on either side; at least one record
    // always goes through it.
    task automatic test_back_to_back();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        do
        begin
            build_record(PROFILE_HIGH22, $urandom_range(0, 2), $urandom_range(1, 2), 1, 4);
            send_record(0, rec_bytes.size(), 1'b1, 1'b1, 0);
        end
        while (parsed_count < TOTAL_TARGET);
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls: random bursts while enabled.
    // ------------------------------------------------------------------

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking: each accepted result against the oldest prediction.
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("result %0d: %s expected %0d, got %0d",
                         result_count, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            observed_label = {field_kind, byte_echo, decoded_value, complete_flag, set_index,
                              payload_offset, last_of_set, record_done, error_code};
            if (expected_labels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result %0d: none expected, got kind %0d byte %0d",
                             result_count, field_kind, byte_echo);
            end
            else
            begin
                wanted_label = expected_labels.pop_front();
                compare_field("field_kind", 16'(wanted_label.field_kind),
                              16'(observed_label.field_kind));
                compare_field("byte_echo", 16'(wanted_label.byte_echo),
                              16'(observed_label.byte_echo));
                compare_field("decoded_value", wanted_label.decoded_value,
                              observed_label.decoded_value);
                compare_field("complete_flag", 16'(wanted_label.complete_flag),
                              16'(observed_label.complete_flag));
                compare_field("set_index", 16'(wanted_label.set_index),
                              16'(observed_label.set_index));
                compare_field("payload_offset", wanted_label.payload_offset,
                              observed_label.payload_offset);
                compare_field("last_of_set", 16'(wanted_label.last_of_set),
                              16'(observed_label.last_of_set));
                compare_field("record_done", 16'(wanted_label.record_done),
                              16'(observed_label.record_done));
                compare_field("error_code", 16'(wanted_label.error_code),
                              16'(observed_label.error_code));
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves for too long.
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'd0;
        record_start   = 1'b0;
        record_end     = 1'b0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        mismatch_count = 0;
        result_count   = 0;
        parsed_count   = 0;
        reset_parse();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_records();
        test_drain_pause();
        test_random_records();
        test_back_to_back();

        // Stop sending, let every outstanding result come back, then keep clocking
        // the two-stage pipeline so that any stray result shows.
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_labels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
